/* rtl/core/binary_pattern_correlator_core_assert.svh */
// Assertion macros for the binary pattern correlator core.
`ifndef BINARY_PATTERN_CORRELATOR_CORE_ASSERT_SVH
`define BINARY_PATTERN_CORRELATOR_CORE_ASSERT_SVH

// Clocked assertion, disabled while reset is asserted.
`define BPC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define BPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/bpc_pkg.sv */
// Package: types, constants and register codes of the pattern correlator.
`default_nettype none
package bpc_pkg;

  localparam int MAX_PATTERN = 64;
  localparam int COUNT_WIDTH = 16;

  localparam int LEN_CFG_W  = 7;
  localparam int SCORE_W    = 8;
  localparam int HC_W       = 16;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;

  localparam int LEN_W   = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W   = $clog2(MAX_PATTERN);
  localparam int GROUP   = 8;
  localparam int NGROUP  = (MAX_PATTERN + GROUP - 1) / GROUP;
  localparam int PART_W  = $clog2(GROUP + 1);
  localparam int DIST_W  = $clog2(MAX_PATTERN + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN   = 2'd0,
    CFG_LENGTH    = 2'd1,
    CFG_THRESHOLD = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic target_bit;
    logic restart;
  } in_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic                      window_full;
    logic                      hit;
    logic [HC_W-1:0]           hit_count;
  } out_t;

  typedef struct packed {
    logic [LEN_W-1:0]          len;
    logic signed [SCORE_W-1:0] threshold;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic full;
    logic restart;
  } stage_t;

endpackage
`default_nettype wire

/* rtl/core/bpc_cfg.sv */
// Configuration registers and alignment of the pattern to the window cells.
`default_nettype none
module bpc_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output bpc_pkg::cfg_t                 cfg,
  output logic [bpc_pkg::MAX_PATTERN-1:0] pat_aligned,
  output logic [bpc_pkg::MAX_PATTERN-1:0] pat_mask
);
  import bpc_pkg::*;

  logic [MAX_PATTERN-1:0]    pattern_r;
  logic [LEN_CFG_W-1:0]      length_r;
  logic signed [SCORE_W-1:0] thresh_r;
  logic [LEN_W-1:0]          len_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      length_r  <= LEN_CFG_W'(8);
      thresh_r  <= SCORE_W'(8);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PATTERN:   pattern_r <= cfg_wdata[MAX_PATTERN-1:0];
        CFG_LENGTH:    length_r  <= cfg_wdata[LEN_CFG_W-1:0];
        CFG_THRESHOLD: thresh_r  <= cfg_wdata[SCORE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (length_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (length_r > LEN_CFG_W'(MAX_PATTERN)) begin
      len_eff = LEN_W'(MAX_PATTERN);
    end else begin
      len_eff = LEN_W'(length_r);
    end
  end

  // Cell k holds the newest-minus-k bit; it pairs with pattern symbol len-1-k.
  always_comb begin
    logic [LEN_W-1:0] idx;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      idx            = len_eff - LEN_W'(1) - LEN_W'(k);
      pat_aligned[k] = pattern_r[idx[IDX_W-1:0]];
      pat_mask[k]    = LEN_W'(k) < len_eff;
    end
  end

  assign cfg.len       = len_eff;
  assign cfg.threshold = thresh_r;

endmodule
`default_nettype wire

/* rtl/core/bpc_cell.sv */
// One window cell: a shift bit plus its aligned pattern bit and mismatch output.
`default_nettype none
module bpc_cell (
  input  logic clk,
  input  logic rst_n,
  input  logic shift_en,
  input  logic din,
  input  logic pat_in,
  input  logic msk_in,
  output logic dout,
  output logic miss
);

  logic w_r;
  logic pat_r;
  logic msk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= 1'b0;
    end else if (shift_en) begin
      w_r <= din;
    end
  end

  always_ff @(posedge clk) begin
    pat_r <= pat_in;
    msk_r <= msk_in;
  end

  assign dout = w_r;
  assign miss = (w_r ^ pat_r) & msk_r;

endmodule
`default_nettype wire

/* rtl/core/bpc_score.sv */
// Mismatch count, score, hit decision, hit counter and output register.
`default_nettype none
module bpc_score (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [bpc_pkg::MAX_PATTERN-1:0] miss,
  input  bpc_pkg::stage_t                 s0,
  input  bpc_pkg::cfg_t                   cfg,
  output logic                            s1_ready,
  output logic                            out_valid,
  input  logic                            out_ready,
  output bpc_pkg::out_t                   out_data
);
  import bpc_pkg::*;

  logic                   v1_r;
  logic                   full1_r;
  logic                   rs1_r;
  logic [PART_W-1:0]      part_r [NGROUP];
  logic [PART_W-1:0]      part_nxt [NGROUP];
  logic                   ov_r;
  out_t                   out_r;
  logic [COUNT_WIDTH-1:0] hits_r;
  logic [COUNT_WIDTH-1:0] hits_nxt;
  logic [DIST_W-1:0]      miss_sum;
  logic signed [SCORE_W-1:0] score;
  logic                   hit;
  logic                   adv2;

  assign adv2     = !ov_r || out_ready;
  assign s1_ready = !v1_r || adv2;

  always_comb begin
    for (int g = 0; g < NGROUP; g++) begin
      part_nxt[g] = '0;
      for (int j = 0; j < GROUP; j++) begin
        if (g * GROUP + j < MAX_PATTERN) begin
          part_nxt[g] = part_nxt[g] + PART_W'(miss[g * GROUP + j]);
        end
      end
    end
  end

  always_comb begin
    logic [COUNT_WIDTH-1:0] base;
    miss_sum = '0;
    for (int g = 0; g < NGROUP; g++) begin
      miss_sum = miss_sum + DIST_W'(part_r[g]);
    end
    score = '0;
    hit   = 1'b0;
    if (full1_r) begin
      score = SCORE_W'(cfg.len) - (SCORE_W'(miss_sum) << 1);
      hit   = score >= cfg.threshold;
    end
    base     = rs1_r ? '0 : hits_r;
    hits_nxt = (hit && base != '1) ? base + COUNT_WIDTH'(1) : base;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (s1_ready) begin
      v1_r <= s0.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      full1_r <= s0.full;
      rs1_r   <= s0.restart;
      part_r  <= part_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r   <= 1'b0;
      hits_r <= '0;
    end else if (adv2) begin
      ov_r <= v1_r;
      if (v1_r) begin
        hits_r <= hits_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && v1_r) begin
      out_r.score       <= score;
      out_r.window_full <= full1_r;
      out_r.hit         <= hit;
      out_r.hit_count   <= HC_W'(hits_nxt);
    end
  end

  assign out_valid = ov_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

/* rtl/core/binary_pattern_correlator_core.sv */
// Each result passes the window, group-count and output registers in order.
// Throughput: one item per cycle unless out_ready stalls; cells shift once per
// transfer, mismatch count in two registered stages (group counts, then sum).
// Reset (synchronous, rst_n low): window, fill count and hit count cleared,
// pattern 0, length 8, threshold 8; no clearing pass.
`default_nettype none
module binary_pattern_correlator_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  bpc_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output bpc_pkg::out_t                   out_data,
  input  logic                            cfg_we,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bpc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import bpc_pkg::*;

  cfg_t                   cfg;
  logic [MAX_PATTERN-1:0] pat_aligned;
  logic [MAX_PATTERN-1:0] pat_mask;
  logic [MAX_PATTERN-1:0] win;
  logic [MAX_PATTERN-1:0] miss;
  logic                   shift_en;
  logic                   s1_ready;
  stage_t                 s0_r;
  stage_t                 s0_nxt;
  logic [LEN_W-1:0]       fill_r;
  logic [LEN_W-1:0]       fill_nxt;

  bpc_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .cfg         (cfg),
    .pat_aligned (pat_aligned),
    .pat_mask    (pat_mask)
  );

  assign in_ready = !s0_r.valid || s1_ready;
  assign shift_en = in_valid && in_ready;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    bpc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .din      ((k == 0) ? in_data.target_bit : win[(k == 0) ? 0 : k - 1]),
      .pat_in   (pat_aligned[k]),
      .msk_in   (pat_mask[k]),
      .dout     (win[k]),
      .miss     (miss[k])
    );
  end

  always_comb begin
    logic [LEN_W-1:0] base;
    base     = in_data.restart ? '0 : fill_r;
    fill_nxt = (base < LEN_W'(MAX_PATTERN)) ? base + LEN_W'(1) : base;
    s0_nxt.valid   = in_valid;
    s0_nxt.full    = fill_nxt >= cfg.len;
    s0_nxt.restart = in_data.restart;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r   <= '0;
      fill_r <= '0;
    end else if (in_ready) begin
      s0_r <= s0_nxt;
      if (in_valid) begin
        fill_r <= fill_nxt;
      end
    end
  end

  bpc_score u_score (
    .clk       (clk),
    .rst_n     (rst_n),
    .miss      (miss),
    .s0        (s0_r),
    .cfg       (cfg),
    .s1_ready  (s1_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

/* rtl/core/bpc_checker.sv */
// Port-level checker for the correlator core, bound to the top level.
`default_nettype none
`include "binary_pattern_correlator_core_assert.svh"
module bpc_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input bpc_pkg::out_t                  out_data
);

  `BPC_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled result changed")
  `BPC_ASSERT(a_hit_full, clk, rst_n, out_valid && out_data.hit |-> out_data.window_full, "hit without full window")
  `BPC_ASSERT(a_score_zero, clk, rst_n, out_valid && !out_data.window_full |-> out_data.score == '0, "score nonzero before full")
  `BPC_ASSERT(a_hit_count, clk, rst_n, out_valid && out_data.hit |-> out_data.hit_count != '0, "hit with zero count")
  `BPC_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind binary_pattern_correlator_core bpc_checker u_bpc_checker (.*);
`default_nettype wire
